### src/bchd_pkg.sv
// Package: types and constants shared by the button click/hold detector.
`timescale 1ns / 1ps
`default_nettype none
package bchd_pkg;

   localparam int NUM_CHANNELS_DEF = 16;
   localparam int RSP_DEPTH        = 4;
   localparam int RSP_PTR_W        = $clog2(RSP_DEPTH);
   localparam int RSP_CNT_W        = $clog2(RSP_DEPTH + 1);
   localparam int CLICK_MAX        = 15;

   localparam logic [3:0]  CLICK_LIMIT_RST    = 4'd5;
   localparam logic [15:0] DEBOUNCE_MS_RST    = 16'd50;
   localparam logic [15:0] MULTI_CLICK_MS_RST = 16'd300;
   localparam logic [15:0] HOLD_MS_RST        = 16'd1000;

   typedef enum logic [1:0] {
      CSR_CLICK_LIMIT    = 2'd0,
      CSR_DEBOUNCE_MS    = 2'd1,
      CSR_MULTI_CLICK_MS = 2'd2,
      CSR_HOLD_MS        = 2'd3
   } csr_idx_type;

   typedef enum logic [2:0] {
      PH_IDLE     = 3'd0,
      PH_DEBOUNCE = 3'd1,
      PH_PRESSED  = 3'd2,
      PH_WAIT     = 3'd3,
      PH_HOLD     = 3'd4
   } phase_type;

   typedef enum logic [1:0] {
      KIND_NONE    = 2'd0,
      KIND_CLICK   = 2'd1,
      KIND_HOLD    = 2'd2,
      KIND_RELEASE = 2'd3
   } kind_type;

   typedef struct packed {
      logic [3:0]  channel;
      logic        pressed;
      logic [31:0] now_ms;
   } req_type;

   typedef struct packed {
      logic        event_valid;
      logic [3:0]  event_channel;
      kind_type    event_kind;
      logic [3:0]  click_count;
      logic [31:0] hold_duration_ms;
      logic        last;
   } rsp_type;

   typedef struct packed {
      phase_type   phase;
      logic [31:0] deadline;
      logic [3:0]  clicks;
      logic [31:0] hold_mark;
   } chan_state_type;

endpackage
`default_nettype wire

### src/button_click_hold_detector.sv
// Top level: per-channel multi-click and hold gesture detector.
//
// Usage: each req_ item is one poll sample (channel, pressed level, ms time).
// Each item yields one or two rsp_ items; the last one of an item has last=1.
// Samples for a channel at or beyond NUM_CHANNELS answer with "no event".
// The csr_ port writes click_limit, debounce_ms, multi_click_ms and hold_ms
// with one write per cycle; write only while no item is in flight.
//
// An accepted item is held and evaluated in the input stage; its results
// go into the result queue as it leaves that stage and are offered on rsp_.
// Throughput: one item per cycle while each item makes one result and rsp_
// is not stalled; an item with two results (hold start with click) queues both.
// The per-channel state memory is read on accept and written back when the
// item leaves the input stage; a sample to the same channel accepted at that
// edge is forwarded.
// A four-entry result queue sits before rsp_; the input stage advances only
// when two entries are free, so a stalled receiver backs up into req_ready.
// Reset: all channels idle (valid bits cleared, no clearing pass), registers
// return to 5, 50, 300 and 1000, the queue is emptied.
`timescale 1ns / 1ps
`default_nettype none
module button_click_hold_detector #(
   parameter int NUM_CHANNELS = bchd_pkg::NUM_CHANNELS_DEF
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_ready,
   input  wire bchd_pkg::req_type     req_data,
   output logic                       rsp_valid,
   input  wire logic                  rsp_ready,
   output bchd_pkg::rsp_type          rsp_data,
   input  wire logic                  csr_we,
   input  wire bchd_pkg::csr_idx_type csr_index,
   input  wire logic [15:0]           csr_wdata
);

   localparam int IDX_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

   // configuration
   logic [3:0]  click_limit_ff;
   logic [15:0] debounce_ms_ff;
   logic [15:0] multi_click_ms_ff;
   logic [15:0] hold_ms_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         click_limit_ff    <= bchd_pkg::CLICK_LIMIT_RST;
         debounce_ms_ff    <= bchd_pkg::DEBOUNCE_MS_RST;
         multi_click_ms_ff <= bchd_pkg::MULTI_CLICK_MS_RST;
         hold_ms_ff        <= bchd_pkg::HOLD_MS_RST;
      end else if (csr_we) begin
         case (csr_index)
            bchd_pkg::CSR_CLICK_LIMIT:    click_limit_ff    <= csr_wdata[3:0];
            bchd_pkg::CSR_DEBOUNCE_MS:    debounce_ms_ff    <= csr_wdata;
            bchd_pkg::CSR_MULTI_CLICK_MS: multi_click_ms_ff <= csr_wdata;
            bchd_pkg::CSR_HOLD_MS:        hold_ms_ff        <= csr_wdata;
            default: ;
         endcase
      end
   end

   // input stage
   logic                         s1_valid_ff;
   bchd_pkg::req_type            s1_req_ff;
   logic                         s1_inr_ff;
   logic                         req_accept;
   logic                         fire;
   logic                         req_inr;
   logic [IDX_W-1:0]             req_idx;
   logic [IDX_W-1:0]             s1_idx;
   logic [bchd_pkg::RSP_CNT_W-1:0] cnt_ff;

   assign req_inr    = (32'(req_data.channel) < NUM_CHANNELS);
   assign req_idx    = IDX_W'(req_data.channel);
   assign s1_idx     = IDX_W'(s1_req_ff.channel);
   // advance only with room for two results
   assign fire       = s1_valid_ff && (cnt_ff <= bchd_pkg::RSP_CNT_W'(bchd_pkg::RSP_DEPTH - 2));
   assign req_ready  = !s1_valid_ff || fire;
   assign req_accept = req_valid && req_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_accept) begin
         s1_valid_ff <= 1'b1;
      end else if (fire) begin
         s1_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_req_ff <= req_data;
         s1_inr_ff <= req_inr;
      end
   end

   // channel state memory with valid bits and write-back forwarding
   bchd_pkg::chan_state_type mem [NUM_CHANNELS];
   bchd_pkg::chan_state_type rd_ff;
   bchd_pkg::chan_state_type byp_st_ff;
   bchd_pkg::chan_state_type cur;
   bchd_pkg::chan_state_type st_in;
   logic [NUM_CHANNELS-1:0]  vld_ff;
   logic                     vld_rd_ff;
   logic                     byp_ff;
   logic                     st_we;

   assign st_we = fire && s1_inr_ff;

   always_ff @(posedge clock) begin
      if (st_we) begin
         mem[s1_idx] <= st_in;
      end
      if (req_accept && req_inr) begin
         rd_ff <= mem[req_idx];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (st_we) begin
         vld_ff[s1_idx] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         vld_rd_ff <= req_inr && vld_ff[req_idx];
         byp_ff    <= st_we && req_inr && (s1_idx == req_idx);
         byp_st_ff <= st_in;
      end
   end

   assign cur = byp_ff ? byp_st_ff : (vld_rd_ff ? rd_ff : '0);

   // gesture evaluation
   logic        dl_passed;
   logic [31:0] dl_diff;
   logic        e_hold;
   logic        e_click;
   logic        e_rel;
   logic [3:0]  e_clicks;
   logic [31:0] e_dur;
   logic [1:0]  push_n;
   bchd_pkg::rsp_type res0;
   bchd_pkg::rsp_type res1;
   bchd_pkg::rsp_type ev_click;
   bchd_pkg::rsp_type ev_other;

   assign dl_diff   = s1_req_ff.now_ms - cur.deadline;
   assign dl_passed = (dl_diff != 32'd0) && !dl_diff[31];

   always_comb begin
      st_in    = cur;
      e_hold   = 1'b0;
      e_click  = 1'b0;
      e_rel    = 1'b0;
      e_clicks = cur.clicks;
      e_dur    = 32'd0;
      if (s1_inr_ff) begin
         case (cur.phase)
            bchd_pkg::PH_IDLE: begin
               if (s1_req_ff.pressed) begin
                  st_in.phase    = bchd_pkg::PH_DEBOUNCE;
                  st_in.deadline = s1_req_ff.now_ms + 32'(debounce_ms_ff);
                  st_in.clicks   = 4'd0;
               end
            end
            bchd_pkg::PH_DEBOUNCE: begin
               if (dl_passed) begin
                  if (cur.clicks != 4'(bchd_pkg::CLICK_MAX)) begin
                     st_in.clicks = cur.clicks + 4'd1;
                  end
                  st_in.phase    = bchd_pkg::PH_PRESSED;
                  st_in.deadline = s1_req_ff.now_ms + 32'(hold_ms_ff);
               end
               if (!s1_req_ff.pressed) begin
                  e_click     = (st_in.clicks != 4'd0);
                  e_clicks    = st_in.clicks;
                  st_in.phase = bchd_pkg::PH_IDLE;
               end
            end
            bchd_pkg::PH_PRESSED: begin
               if (dl_passed) begin
                  e_hold          = 1'b1;
                  st_in.phase     = bchd_pkg::PH_HOLD;
                  st_in.hold_mark = s1_req_ff.now_ms;
               end
               if (!s1_req_ff.pressed) begin
                  if (cur.clicks >= click_limit_ff) begin
                     st_in.phase = bchd_pkg::PH_IDLE;
                     e_click     = 1'b1;
                  end else begin
                     st_in.phase    = bchd_pkg::PH_WAIT;
                     st_in.deadline = s1_req_ff.now_ms + 32'(multi_click_ms_ff);
                  end
               end
            end
            bchd_pkg::PH_WAIT: begin
               if (dl_passed) begin
                  st_in.phase  = bchd_pkg::PH_IDLE;
                  e_click      = 1'b1;
                  st_in.clicks = 4'd0;
               end
               if (s1_req_ff.pressed) begin
                  st_in.phase    = bchd_pkg::PH_DEBOUNCE;
                  st_in.deadline = s1_req_ff.now_ms + 32'(debounce_ms_ff);
               end
            end
            bchd_pkg::PH_HOLD: begin
               if (!s1_req_ff.pressed) begin
                  e_rel       = 1'b1;
                  e_dur       = s1_req_ff.now_ms - cur.hold_mark + 32'(hold_ms_ff);
                  st_in.phase = bchd_pkg::PH_IDLE;
               end
            end
            default: begin
               st_in.phase = bchd_pkg::PH_IDLE;
            end
         endcase
      end
   end

   // assemble results: hold start always comes before a click
   always_comb begin
      ev_click                  = '0;
      ev_click.event_valid      = 1'b1;
      ev_click.event_channel    = s1_req_ff.channel;
      ev_click.event_kind       = bchd_pkg::KIND_CLICK;
      ev_click.click_count      = e_clicks;

      ev_other                  = '0;
      ev_other.event_channel    = s1_req_ff.channel;
      ev_other.event_kind       = bchd_pkg::KIND_NONE;
      if (e_hold) begin
         ev_other.event_valid   = 1'b1;
         ev_other.event_kind    = bchd_pkg::KIND_HOLD;
      end else if (e_rel) begin
         ev_other.event_valid   = 1'b1;
         ev_other.event_kind    = bchd_pkg::KIND_RELEASE;
         ev_other.hold_duration_ms = e_dur;
      end

      res1 = ev_click;
      if (e_hold && e_click) begin
         res0   = ev_other;
         push_n = 2'd2;
      end else if (e_click) begin
         res0   = ev_click;
         push_n = 2'd1;
      end else begin
         res0   = ev_other;
         push_n = 2'd1;
      end
      res0.last = (push_n == 2'd1);
      res1.last = 1'b1;
   end

   // result queue
   bchd_pkg::rsp_type               rsp_q [bchd_pkg::RSP_DEPTH];
   logic [bchd_pkg::RSP_PTR_W-1:0]  wr_ptr_ff;
   logic [bchd_pkg::RSP_PTR_W-1:0]  wr_ptr_nx1;
   logic [bchd_pkg::RSP_PTR_W-1:0]  rd_ptr_ff;
   logic [bchd_pkg::RSP_CNT_W-1:0]  cnt_in;
   logic [bchd_pkg::RSP_CNT_W-1:0]  push_cnt;
   logic                            pop;

   assign wr_ptr_nx1 = wr_ptr_ff + bchd_pkg::RSP_PTR_W'(1);
   assign rsp_valid  = (cnt_ff != '0);
   assign rsp_data   = rsp_q[rd_ptr_ff];
   assign pop        = rsp_valid && rsp_ready;
   assign push_cnt   = fire ? bchd_pkg::RSP_CNT_W'(push_n) : '0;
   assign cnt_in     = cnt_ff + push_cnt - bchd_pkg::RSP_CNT_W'(pop);

   always_ff @(posedge clock) begin
      if (fire) begin
         rsp_q[wr_ptr_ff] <= res0;
         if (push_n == 2'd2) begin
            rsp_q[wr_ptr_nx1] <= res1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         cnt_ff <= cnt_in;
         if (fire) begin
            wr_ptr_ff <= wr_ptr_ff + bchd_pkg::RSP_PTR_W'(push_n);
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + bchd_pkg::RSP_PTR_W'(1);
         end
      end
   end

   // checks
   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= bchd_pkg::RSP_CNT_W'(bchd_pkg::RSP_DEPTH))
      else $error("result queue overflow");

   a_two_starts_hold: assert property (@(posedge clock) disable iff (reset)
      (fire && push_n == 2'd2) |-> (res0.event_kind == bchd_pkg::KIND_HOLD && !res0.last))
      else $error("two results without hold start first");

   a_accept_loads: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> (s1_valid_ff && cnt_ff <= bchd_pkg::RSP_CNT_W'(bchd_pkg::RSP_DEPTH)))
      else $error("accepted item not held in input stage");

   a_fire_pushes: assert property (@(posedge clock) disable iff (reset)
      fire |=> (cnt_ff != '0))
      else $error("evaluated item left no result");

endmodule
`default_nettype wire
